// File: hw/rtl/pctdec_pkg.sv
// Shared types, constants and helper functions of the percent decoder.
package pctdec_pkg;

  localparam logic [7:0] PctChar     = 8'h25;
  localparam int unsigned NibbleShift = 4;

  // Pending state codes of the front end
  localparam logic [1:0] PendNone  = 2'd0;
  localparam logic [1:0] PendPct   = 2'd1;
  localparam logic [1:0] PendDigit = 2'd2;

  // Command queue between front and back (depth must be a power of two)
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = QPtrW + 1;

  // One command: up to three output words, the final one carries last.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } cmd_t;

  // Front to queue
  typedef struct packed {
    logic push;
    cmd_t cmd;
  } push_t;

  // Queue status towards front and back
  typedef struct packed {
    logic full;
    logic valid;
    cmd_t head;
  } qstat_t;

  function automatic logic hex_valid(input logic [7:0] c);
    hex_valid = (c >= 8'h30 && c <= 8'h39) ||
                (c >= 8'h41 && c <= 8'h46) ||
                (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h41 + 8'd10;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h61 + 8'd10;
    end
    hex_nibble = v[3:0];
  endfunction

endpackage

// File: hw/rtl/pctdec_if.sv
// Valid/ready stream interfaces for encoded input and decoded output words.
interface pctdec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pctdec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: hw/rtl/percent_decoder_core.sv
// Top level of the streaming URL percent decoder.
// An input word's results pass through the command queue and then the output register.
// Throughput: one input word per cycle while the queue is not full; the output register
//   drains one word per cycle while the output is ready, one for each result of a word.
// The two-entry command queue lets the front end keep accepting while the back end expands.
// Reset (rst_ni, asynchronous, active low) empties the queue and clears the escape state.
module percent_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  pctdec_in_if.sink          in_ch,
  pctdec_out_if.source       out_ch
);
  import pctdec_pkg::*;

  push_t            push;
  qstat_t           qstat;
  logic             pop;
  logic [1:0]       pend;
  logic [1:0]       idx;
  logic [QCntW-1:0] qcount;

  // Front end: escape tracking, one command per word that yields results
  pctdec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_byte_i  (in_ch.in_byte),
    .in_last_i  (in_ch.in_last),
    .in_ready_o (in_ch.ready),
    .qstat_i    (qstat),
    .push_o     (push),
    .pend_o     (pend)
  );

  // Command queue decoupling the two sides
  pctdec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .qstat_o (qstat),
    .count_o (qcount)
  );

  // Back end: emits one word per cycle from the queue head while the output is ready
  pctdec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .out_valid_o (out_ch.valid),
    .out_byte_o  (out_ch.out_byte),
    .out_last_o  (out_ch.out_last),
    .out_ready_i (out_ch.ready),
    .idx_o       (idx)
  );

  // The final word of a string always leaves nothing held
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready && in_ch.in_last) |=> (pend == PendNone))
    else $error("escape state held after final word");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push |-> (qcount != QCntW'(QueueDepth)))
    else $error("command queue overflow");

  // Expansion index stays inside the head command
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.valid |-> (idx < qstat.head.cnt))
    else $error("expansion index beyond command length");

endmodule

// File: hw/rtl/pctdec_front.sv
// Front end: accepts input words, tracks escapes, builds output commands.
module pctdec_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  pctdec_pkg::qstat_t qstat_i,
  output pctdec_pkg::push_t push_o,
  output logic [1:0]        pend_o
);
  import pctdec_pkg::*;

  logic [1:0] pend_q, pend_d;
  logic [7:0] first_q, first_d;
  logic       accept;
  logic       fresh_pct;
  cmd_t       cmd;

  assign in_ready_o = !qstat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  // a '%' that is not the final word starts an escape
  assign fresh_pct  = (in_byte_i == PctChar) && !in_last_i;

  always_comb begin
    pend_d   = pend_q;
    first_d  = first_q;
    cmd.b0   = PctChar;
    cmd.b1   = first_q;
    cmd.b2   = in_byte_i;
    cmd.last = in_last_i;
    cmd.cnt  = 2'd0;
    unique case (pend_q)
      PendPct: begin
        if (hex_valid(in_byte_i)) begin
          if (in_last_i) begin
            cmd.b1  = in_byte_i;
            cmd.cnt = 2'd2;
            pend_d  = PendNone;
          end else begin
            first_d = in_byte_i;
            pend_d  = PendDigit;
          end
        end else begin
          // literal '%', then the word again as fresh
          cmd.b1 = in_byte_i;
          if (fresh_pct) begin
            cmd.cnt = 2'd1;
            pend_d  = PendPct;
          end else begin
            cmd.cnt = 2'd2;
            pend_d  = PendNone;
          end
        end
      end
      PendDigit: begin
        if (hex_valid(in_byte_i)) begin
          cmd.b0  = {hex_nibble(first_q), hex_nibble(in_byte_i)};
          cmd.cnt = 2'd1;
          pend_d  = PendNone;
        end else begin
          // literal '%' and held digit, then the word as fresh
          if (fresh_pct) begin
            cmd.cnt = 2'd2;
            pend_d  = PendPct;
          end else begin
            cmd.cnt = 2'd3;
            pend_d  = PendNone;
          end
        end
      end
      default: begin
        cmd.b0 = in_byte_i;
        if (fresh_pct) begin
          cmd.cnt = 2'd0;
          pend_d  = PendPct;
        end else begin
          cmd.cnt = 2'd1;
          pend_d  = PendNone;
        end
      end
    endcase
  end

  assign push_o.push = accept && (cmd.cnt != 2'd0);
  assign push_o.cmd  = cmd;
  assign pend_o      = pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PendNone;
    end else if (accept) begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 8'h00;
    end else if (accept) begin
      first_q <= first_d;
    end
  end

endmodule

// File: hw/rtl/pctdec_queue.sv
// Short command queue between the front and back ends.
module pctdec_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pctdec_pkg::push_t  push_i,
  input  logic               pop_i,
  output pctdec_pkg::qstat_t qstat_o,
  output logic [pctdec_pkg::QCntW-1:0] count_o
);
  import pctdec_pkg::*;

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i.push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i.push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

  assign qstat_o.full  = (cnt_q == QCntW'(QueueDepth));
  assign qstat_o.valid = (cnt_q != '0);
  assign qstat_o.head  = mem_q[rd_ptr_q];
  assign count_o       = cnt_q;

endmodule

// File: hw/rtl/pctdec_back.sv
// Back end: expands queued commands into output words via an output register.
module pctdec_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pctdec_pkg::qstat_t qstat_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o,
  input  logic               out_ready_i,
  output logic [1:0]         idx_o
);
  import pctdec_pkg::*;

  logic [1:0] idx_q;
  logic       ov_q;
  logic [7:0] ob_q;
  logic       ol_q;
  logic       load;
  logic       final_w;
  logic [7:0] sel;

  assign load    = qstat_i.valid && (!ov_q || out_ready_i);
  assign final_w = ((idx_q + 2'd1) == qstat_i.head.cnt);
  assign pop_o   = load && final_w;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel = qstat_i.head.b0;
      2'd1:    sel = qstat_i.head.b1;
      default: sel = qstat_i.head.b2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      ov_q  <= 1'b0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= final_w ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ob_q <= sel;
      ol_q <= qstat_i.head.last && final_w;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_last_o  = ol_q;
  assign idx_o       = idx_q;

endmodule
